// ===== sv/fpr_pkg.sv =====
// Shared constants and types for the FIFO page replacement block.
package fpr_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;
	localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
	localparam int CFG_W      = 5;
	localparam int CMP_W      = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam int FAULT_W    = 24;

	localparam logic [CFG_W-1:0]   FRAME_COUNT_RESET = CFG_W'(4);
	localparam logic [FAULT_W-1:0] FAULT_MAX         = {FAULT_W{1'b1}};

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [OCC_W-1:0]     occ_t;
	typedef logic [FAULT_W-1:0]   fault_t;
	typedef logic [CFG_W-1:0]     cfg_t;

	// Per-cell update controls from the chain controller.
	typedef struct packed {
		logic live;   // cell holds a resident page
		logic shift;  // take the neighbor's page
		logic load;   // take the new page
	} cell_ctrl_t;

endpackage

// ===== sv/fpr_cell.sv =====
// One frame cell: holds a page, compares it, hands it down the chain.
module fpr_cell (
	input  logic               clk,
	input  fpr_pkg::cell_ctrl_t ctrl,
	input  fpr_pkg::page_t     new_page,
	input  fpr_pkg::page_t     neighbor_page,
	input  fpr_pkg::page_t     lookup_page,
	output fpr_pkg::page_t     page,
	output logic               match
);
	import fpr_pkg::*;

	page_t page_q;

	assign page  = page_q;
	assign match = ctrl.live && (page_q == lookup_page);

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			page_q <= new_page;
		end else if (ctrl.shift) begin
			page_q <= neighbor_page;
		end else begin
			page_q <= page_q;
		end
	end

endmodule

// ===== sv/fifo_page_replacement.sv =====
// FIFO page replacement: a chain of frame cells, oldest page in cell 0.
// Results are registered: a result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; all cells compare in
// parallel and the chain shifts by one on an eviction in the same cycle.
// Reset: occupancy and fault count clear, frame_count returns to 4; cell
// contents are not reset and are only read below the occupancy.
module fifo_page_replacement (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  fpr_pkg::cfg_t          cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  fpr_pkg::page_t         page_number,
	input  logic                   list_start,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic                   evicted_valid,
	output fpr_pkg::page_t         evicted_page,
	output fpr_pkg::fault_t        fault_total,
	output fpr_pkg::occ_t          resident_count
);
	import fpr_pkg::*;

	cfg_t       frame_count_q;
	occ_t       occ_q;
	fault_t     fault_q;

	logic       out_valid_q;
	logic       hit_q;
	logic       ev_valid_q;
	page_t      ev_page_q;
	fault_t     fault_out_q;
	occ_t       occ_out_q;

	logic       accept;
	logic       miss;
	logic       evict;
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] fc_wide;
	occ_t       tail;
	occ_t       occ_next;
	fault_t     fault_base;
	fault_t     fault_next;

	page_t      cell_page [MAX_FRAMES];
	page_t      cell_nbr  [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] cell_match;
	cell_ctrl_t cell_ctrl [MAX_FRAMES];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Clamp the frame count to 1..MAX_FRAMES.
	assign fc_wide = CMP_W'(frame_count_q);
	always_comb begin
		priority if (fc_wide == '0) begin
			limit = CMP_W'(1);
		end else if (fc_wide > CMP_W'(MAX_FRAMES)) begin
			limit = CMP_W'(MAX_FRAMES);
		end else begin
			limit = fc_wide;
		end
	end

	assign miss  = !(|cell_match);
	assign evict = miss && (CMP_W'(occ_q) >= limit) && (occ_q != '0);
	assign tail  = evict ? occ_q - occ_t'(1) : occ_q;
	assign occ_next = evict ? occ_q : occ_q + occ_t'(1);

	assign fault_base = list_start ? '0 : fault_q;
	assign fault_next = (miss && (fault_base != FAULT_MAX)) ? fault_base + fault_t'(1)
	                                                          : fault_base;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
			if (gi == MAX_FRAMES - 1) begin : g_last
				assign cell_nbr[gi] = '0;
			end else begin : g_mid
				assign cell_nbr[gi] = cell_page[gi+1];
			end

			assign cell_ctrl[gi] = '{
				live:  occ_q > occ_t'(gi),
				shift: accept && evict,
				load:  accept && miss && (tail == occ_t'(gi))
			};

			fpr_cell u_cell (
				.clk           (clk),
				.ctrl          (cell_ctrl[gi]),
				.new_page      (page_number),
				.neighbor_page (cell_nbr[gi]),
				.lookup_page   (page_number),
				.page          (cell_page[gi]),
				.match         (cell_match[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
			occ_q         <= '0;
			fault_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				frame_count_q <= cfg_wdata;
			end
			if (accept) begin
				fault_q     <= fault_next;
				out_valid_q <= 1'b1;
				if (miss) begin
					occ_q <= occ_next;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register; holds while the request downstream is stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q       <= !miss;
			ev_valid_q  <= evict;
			ev_page_q   <= evict ? cell_page[0] : '0;
			fault_out_q <= fault_next;
			occ_out_q   <= miss ? occ_next : occ_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign evicted_valid  = ev_valid_q;
	assign evicted_page   = ev_page_q;
	assign fault_total    = fault_out_q;
	assign resident_count = occ_out_q;

endmodule

// ===== sv/fpr_checker.sv =====
// Port-level checker for the FIFO page replacement block, with its bind.
module fpr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input logic            hit,
	input logic            evicted_valid,
	input fpr_pkg::page_t  evicted_page,
	input fpr_pkg::occ_t   resident_count
);
	import fpr_pkg::*;

	// An eviction only happens on a fault.
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> !hit)
		else $error("eviction reported on a hit");

	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted_valid |-> evicted_page == '0)
		else $error("evicted page nonzero without eviction");

	// A resident page always exists after any result, and at most MAX_FRAMES are resident.
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (resident_count != '0) && (resident_count <= occ_t'(MAX_FRAMES)))
		else $error("resident count out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(evicted_page)
			&& $stable(resident_count))
		else $error("stalled result changed");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.hit            (hit),
	.evicted_valid  (evicted_valid),
	.evicted_page   (evicted_page),
	.resident_count (resident_count)
);

// ===== sim/tb_fifo_page_replacement.sv =====
// Self-checking testbench for the FIFO page replacement block.
`timescale 1ns / 1ps

module tb_fifo_page_replacement;
	import fpr_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic   hit;
		logic   ev_valid;
		page_t  ev_page;
		fault_t faults;
		occ_t   occ;
	} lookup_t;

	typedef struct {
		bit      cfg_wr;
		cfg_t    cfg_val;
		page_t   pg;
		logic    st;
		bit      typed;
		lookup_t want;
	} ref_row_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_wen;
	cfg_t   cfg_wdata;
	logic   in_valid;
	logic   in_stall;
	page_t  page_number;
	logic   list_start;
	logic   out_valid;
	logic   out_stall;
	logic   hit;
	logic   evicted_valid;
	page_t  evicted_page;
	fault_t fault_total;
	occ_t   resident_count;

	// Predictor state
	page_t   resident[MAX_FRAMES];
	int      resident_cnt;
	fault_t  fault_cnt;
	cfg_t    frames_cfg;
	lookup_t pending_lookups[$];

	int mismatches;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	ref_row_t directed_rows[15];

	fifo_page_replacement i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.page_number    (page_number),
		.list_start     (list_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.fault_total    (fault_total),
		.resident_count (resident_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic lookup_t fifo_lookup(input page_t pg, input logic st);
		lookup_t r;
		int      lim;
		bit      found;
		r = '0;
		found = 1'b0;
		if (st) begin
			fault_cnt = '0;
		end
		for (int i = 0; i < resident_cnt; i++) begin
			if (resident[i] == pg) begin
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
		end else begin
			lim = (frames_cfg == 0) ? 1 : (int'(frames_cfg) > MAX_FRAMES) ? MAX_FRAMES
				: int'(frames_cfg);
			// evict only the oldest, even when the count was lowered below occupancy
			if (resident_cnt >= lim && resident_cnt > 0) begin
				r.ev_valid = 1'b1;
				r.ev_page  = resident[0];
				for (int i = 1; i < resident_cnt; i++) begin
					resident[i-1] = resident[i];
				end
				resident_cnt--;
			end
			if (resident_cnt < MAX_FRAMES) begin
				resident[resident_cnt] = pg;
				resident_cnt++;
			end
			if (fault_cnt != FAULT_MAX) begin
				fault_cnt++;
			end
		end
		r.faults = fault_cnt;
		r.occ    = occ_t'(resident_cnt);
		return r;
	endfunction

	// Drive one request, hold it until accepted, then queue its expected lookup.
	task automatic send_req(input page_t pg, input logic st, input bit typed,
			input lookup_t want);
		lookup_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		page_number <= pg;
		list_start  <= st;
		do @(posedge clk); while (in_stall);
		predicted = fifo_lookup(pg, st);
		pending_lookups.insert(pending_lookups.size(), typed ? want : predicted);
		@(negedge clk);
	endtask

	// Drain all outstanding results, then write the frame count.
	task automatic write_frame_count(input cfg_t value);
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0) begin
			@(negedge clk);
		end
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen    <= 1'b0;
		frames_cfg = value;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result hit=%0d fault_total=%0d", $realtime, hit,
					fault_total);
				mismatches++;
			end else begin
				want = pending_lookups[0];
				pending_lookups.delete(0);
				if (hit !== want.hit) begin
					$display("%0t: hit expected %0d actual %0d", $realtime, want.hit, hit);
					mismatches++;
				end
				if (evicted_valid !== want.ev_valid) begin
					$display("%0t: evicted_valid expected %0d actual %0d", $realtime,
						want.ev_valid, evicted_valid);
					mismatches++;
				end
				if (evicted_page !== want.ev_page) begin
					$display("%0t: evicted_page expected %h actual %h", $realtime,
						want.ev_page, evicted_page);
					mismatches++;
				end
				if (fault_total !== want.faults) begin
					$display("%0t: fault_total expected %0d actual %0d", $realtime,
						want.faults, fault_total);
					mismatches++;
				end
				if (resident_count !== want.occ) begin
					$display("%0t: resident_count expected %0d actual %0d", $realtime,
						want.occ, resident_count);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		cfg_t  cv;
		page_t pool[24];
		page_t pg;
		logic  st;
		int    eff;
		int    span;
		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		page_number    = '0;
		list_start     = 1'b0;
		out_stall      = 1'b0;
		mismatches     = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 6;
		recv_stall_pct = 85;
		resident_cnt   = 0;
		fault_cnt      = '0;
		frames_cfg     = FRAME_COUNT_RESET;
		foreach (resident[i]) resident[i] = '0;

		// cfg_wr, cfg_val, page, list_start, typed, {hit, ev_valid, ev_page, faults, occ}
		directed_rows = '{
			'{0, 0,  16'h0000, 1, 1, '{1'b0, 1'b0, 16'h0000, 24'd1, 5'd1}},
			'{0, 0,  16'hffff, 0, 1, '{1'b0, 1'b0, 16'h0000, 24'd2, 5'd2}},
			'{0, 0,  16'h0000, 0, 1, '{1'b1, 1'b0, 16'h0000, 24'd2, 5'd2}},
			'{0, 0,  16'h0001, 0, 1, '{1'b0, 1'b0, 16'h0000, 24'd3, 5'd3}},
			'{0, 0,  16'h0002, 0, 1, '{1'b0, 1'b0, 16'h0000, 24'd4, 5'd4}},
			'{0, 0,  16'h0003, 0, 1, '{1'b0, 1'b1, 16'h0000, 24'd5, 5'd4}},
			'{0, 0,  16'h0000, 1, 1, '{1'b0, 1'b1, 16'hffff, 24'd1, 5'd4}},
			// frame count above capacity
			'{1, 31, 16'h5555, 0, 0, '0},
			'{0, 0,  16'haaaa, 0, 0, '0},
			// zero frame count, set now far above it
			'{1, 0,  16'h0007, 0, 0, '0},
			'{0, 0,  16'h0002, 0, 0, '0},
			'{0, 0,  16'h0008, 0, 0, '0},
			'{1, 16, 16'h0009, 0, 0, '0},
			'{1, 1,  16'h0009, 1, 0, '0},
			'{0, 0,  16'h000a, 0, 0, '0}
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].cfg_wr) begin
				write_frame_count(directed_rows[r].cfg_val);
			end
			send_req(directed_rows[r].pg, directed_rows[r].st, directed_rows[r].typed,
				directed_rows[r].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 85 : 0;
			recv_stall_pct = (phase == 0) ? 85 : (phase == 1) ? 6 : 0;
			for (int chunk = 0; chunk < 7; chunk++) begin
				case ($urandom_range(0, 5))
					0: cv = 5'd0;
					1: cv = 5'd1;
					2: cv = 5'd16;
					3: cv = 5'd31;
					default: cv = cfg_t'($urandom_range(0, 31));
				endcase
				write_frame_count(cv);
				eff = (cv == 0) ? 1 : (int'(cv) > MAX_FRAMES) ? MAX_FRAMES : int'(cv);
				span = (eff + 2 > 23) ? 23 : eff + 2;
				foreach (pool[i]) pool[i] = page_t'($urandom);
				for (int n = 0; n < 34; n++) begin
					if ($urandom_range(0, 99) < 15) begin
						pg = page_t'($urandom_range(0, 65535));
					end else begin
						pg = pool[$urandom_range(0, span)];
					end
					st = ($urandom_range(0, 19) == 0);
					send_req(pg, st, 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_lookups.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		if (pending_lookups.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, pending_lookups.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
